FILE: rtl/gtea_pkg.sv
// ----------------------------------------------------------------------------
// gtea_pkg
// Shared widths, operation codes, memory port types and the result type for the group
// table element arithmetic block.
// ----------------------------------------------------------------------------
package gtea_pkg;

  localparam int ELEM_W       = 6;
  localparam int OP_W         = 3;
  localparam int EXP_W        = 16;
  localparam int ORD_W        = 7;
  localparam int MAX_ELEMENTS = 64;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  localparam int PROD_AW      = 2 * ELEM_W;
  localparam int PROD_DEPTH   = 1 << PROD_AW;
  localparam int INV_DEPTH    = 1 << ELEM_W;

  localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd1;
  localparam logic [OP_W-1:0] OP_INV   = 3'd2;
  localparam logic [OP_W-1:0] OP_CONJ  = 3'd3;
  localparam logic [OP_W-1:0] OP_COMM  = 3'd4;
  localparam logic [OP_W-1:0] OP_POW   = 3'd5;
  localparam logic [OP_W-1:0] OP_ORDER = 3'd6;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic               we;
    logic [PROD_AW-1:0] waddr;
    elem_t              wdata;
    logic [PROD_AW-1:0] raddr;
  } prod_port_t;

  typedef struct packed {
    logic  we;
    elem_t waddr;
    elem_t wdata;
    elem_t raddr;
  } inv_port_t;

  typedef struct packed {
    logic             valid;
    elem_t            element;
    logic [ORD_W-1:0] order_count;
    logic             no_order;
  } res_t;

endpackage

FILE: rtl/gtea_ram.sv
// ----------------------------------------------------------------------------
// gtea_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module gtea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/gtea_seq.sv
// ----------------------------------------------------------------------------
// gtea_seq
// Sequencer: takes one beat, walks the table reads it needs (one dependent
// read per cycle, read data fed straight into the next address) and holds
// the result until the output register takes it.
// ----------------------------------------------------------------------------
module gtea_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gtea_pkg::OP_W-1:0]   op_in,
  input  gtea_pkg::elem_t             a_in,
  input  gtea_pkg::elem_t             b_in,
  input  logic [gtea_pkg::EXP_W-1:0]  exp_in,
  input  gtea_pkg::elem_t             val_in,
  output logic                        idle,
  output gtea_pkg::prod_port_t        prod_port,
  output gtea_pkg::inv_port_t         inv_port,
  input  gtea_pkg::elem_t             prod_rdata,
  input  gtea_pkg::elem_t             inv_rdata,
  output gtea_pkg::res_t              res,
  input  logic                        take
);
  import gtea_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state, state_next;
  logic [2:0]       phase, phase_next;
  logic [OP_W-1:0]  op;
  elem_t            a, b, val;
  logic [EXP_W-1:0] ex, ex_next;
  elem_t            base, base_next;
  elem_t            acc, acc_next;
  elem_t            tmp, tmp_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             pend, pend_next;
  logic             pend_acc, pend_acc_next;
  elem_t            res_elem, res_elem_next;
  logic [ORD_W-1:0] res_ord, res_ord_next;
  logic             res_no, res_no_next;

  elem_t              acc_eff, base_eff;
  logic [CNT_W:0]     cnt_inc;
  logic [ORD_W+CNT_W-1:0] ord_wide;

  assign acc_eff  = (pend && pend_acc)  ? prod_rdata : acc;
  assign base_eff = (pend && !pend_acc) ? prod_rdata : base;
  assign cnt_inc  = {1'b0, cnt} + 1'b1;
  assign ord_wide = (ORD_W + CNT_W)'(cnt) + 1'b1;

  assign idle = (state == S_IDLE);
  assign res  = '{valid: (state == S_FIN), element: res_elem,
                  order_count: res_ord, no_order: res_no};

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    ex_next       = ex;
    base_next     = base;
    acc_next      = acc;
    tmp_next      = tmp;
    cnt_next      = cnt;
    pend_next     = 1'b0;
    pend_acc_next = pend_acc;
    res_elem_next = res_elem;
    res_ord_next  = res_ord;
    res_no_next   = res_no;
    prod_port     = '0;
    inv_port      = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RUN;
          phase_next = '0;
          ex_next    = exp_in;
          base_next  = a_in;
          acc_next   = '0;
          cnt_next   = '0;
        end
      end
      S_RUN: begin
        // finish by default; arms that keep walking override
        state_next    = S_FIN;
        res_elem_next = '0;
        res_ord_next  = '0;
        res_no_next   = 1'b0;
        phase_next    = phase + 3'd1;
        case (op)
          OP_LOAD: begin
            prod_port.we    = 1'b1;
            prod_port.waddr = {a, b};
            prod_port.wdata = val;
            inv_port.we     = (val == '0);
            inv_port.waddr  = a;
            inv_port.wdata  = b;
          end
          OP_MUL: begin
            if (phase == 3'd0) begin
              prod_port.raddr = {a, b};
              state_next      = S_RUN;
            end else begin
              res_elem_next = prod_rdata;
            end
          end
          OP_INV: begin
            if (phase == 3'd0) begin
              inv_port.raddr = a;
              state_next     = S_RUN;
            end else begin
              res_elem_next = inv_rdata;
            end
          end
          OP_CONJ: begin
            state_next = S_RUN;
            case (phase)
              3'd0: inv_port.raddr = b;
              3'd1: prod_port.raddr = {inv_rdata, a};
              3'd2: prod_port.raddr = {prod_rdata, b};
              default: begin
                state_next    = S_FIN;
                res_elem_next = prod_rdata;
              end
            endcase
          end
          OP_COMM: begin
            state_next = S_RUN;
            case (phase)
              3'd0: inv_port.raddr = a;
              3'd1: begin
                tmp_next       = inv_rdata;
                inv_port.raddr = b;
              end
              3'd2: prod_port.raddr = {tmp, inv_rdata};
              3'd3: prod_port.raddr = {prod_rdata, a};
              3'd4: prod_port.raddr = {prod_rdata, b};
              default: begin
                state_next    = S_FIN;
                res_elem_next = prod_rdata;
              end
            endcase
          end
          OP_POW: begin
            // square-and-multiply, one table read per cycle
            base_next = base_eff;
            acc_next  = acc_eff;
            if (ex == '0) begin
              res_elem_next = acc_eff;
            end else begin
              state_next = S_RUN;
              pend_next  = 1'b1;
              if (ex[0]) begin
                prod_port.raddr = {base_eff, acc_eff};
                pend_acc_next   = 1'b1;
                ex_next         = ex - 1'b1;
              end else begin
                prod_port.raddr = {base_eff, base_eff};
                pend_acc_next   = 1'b0;
                ex_next         = ex >> 1;
              end
            end
          end
          OP_ORDER: begin
            if (a == '0) begin
              res_ord_next = ORD_W'(1);
            end else if (pend && prod_rdata == '0) begin
              res_ord_next = ord_wide[ORD_W-1:0];
            end else if (pend && cnt == CNT_W'(MAX_ELEMENTS)) begin
              res_no_next = 1'b1;
            end else begin
              state_next      = S_RUN;
              prod_port.raddr = {a, acc_eff};
              acc_next        = acc_eff;
              pend_next       = 1'b1;
              pend_acc_next   = 1'b1;
              cnt_next        = cnt_inc[CNT_W-1:0];
            end
          end
          default: begin
          end
        endcase
        if (op == OP_ORDER && phase == 3'd0) begin
          // first order read walks from a itself
          acc_next = (a == '0) ? acc_next : acc_next;
        end
      end
      S_FIN: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
    if (start && state == S_IDLE) begin
      op  <= op_in;
      a   <= a_in;
      b   <= b_in;
      val <= val_in;
    end
    phase    <= phase_next;
    ex       <= ex_next;
    base     <= base_next;
    acc      <= (start && state == S_IDLE && op_in == OP_ORDER) ? a_in : acc_next;
    tmp      <= tmp_next;
    cnt      <= cnt_next;
    pend_acc <= pend_acc_next;
    res_elem <= res_elem_next;
    res_ord  <= res_ord_next;
    res_no   <= res_no_next;
  end

`ifndef SYNTHESIS
  a_write_only_load: assert property (@(posedge clk) disable iff (rst)
    prod_port.we |-> (state == S_RUN && op == OP_LOAD))
    else $error("table write outside a load");

  a_pend_after_run: assert property (@(posedge clk) disable iff (rst)
    pend |-> ($past(state) == S_RUN && state != S_IDLE))
    else $error("read pending outside a walk");

  a_no_order_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.no_order) |-> (res.element == '0 && res.order_count == '0))
    else $error("no_order result carries data");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !take) |=> (res.valid && $stable(res_elem) && $stable(res_ord)))
    else $error("held result changed");
`endif

endmodule

FILE: rtl/group_table_element_arithmetic.sv
// Table reads: power makes at most 31 reads, order at most MAX_ELEMENTS steps
//   of the walk.
// Flow: one beat in flight; the next beat is taken in the cycle after the
//   sequencer hands its result to the output register.
// Reset: rst (synchronous) clears sequencer and output valid; tables are not cleared.
// ----------------------------------------------------------------------------
// group_table_element_arithmetic
// Finite-group arithmetic over a loaded multiplication table: product,
// inverse, conjugate, commutator, power and element order.
// ----------------------------------------------------------------------------
module group_table_element_arithmetic (
  input  logic                        clk,
  input  logic                        rst,
  // item channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [gtea_pkg::OP_W-1:0]   op,
  input  gtea_pkg::elem_t             elem_a,
  input  gtea_pkg::elem_t             elem_b,
  input  logic [gtea_pkg::EXP_W-1:0]  exponent,
  input  gtea_pkg::elem_t             entry_value,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output gtea_pkg::elem_t             element,
  output logic [gtea_pkg::ORD_W-1:0]  order_count,
  output logic                        no_order
);
  import gtea_pkg::*;

  logic       idle;
  logic       start;
  logic       take;
  prod_port_t prod_port;
  inv_port_t  inv_port;
  elem_t      prod_rdata;
  elem_t      inv_rdata;
  res_t       res;

  // Take a new beat only when the sequencer is free; the output register
  // decouples this from the downstream stall.
  assign item_stall = !idle;
  assign start      = item_valid && idle;

  // Move the finished result into the output register whenever it is empty
  // or being drained this cycle.
  assign take = res.valid && (!result_valid || !result_stall);

  gtea_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op_in      (op),
    .a_in       (elem_a),
    .b_in       (elem_b),
    .exp_in     (exponent),
    .val_in     (entry_value),
    .idle       (idle),
    .prod_port  (prod_port),
    .inv_port   (inv_port),
    .prod_rdata (prod_rdata),
    .inv_rdata  (inv_rdata),
    .res        (res),
    .take       (take)
  );

  // Product table, row-major: address is {row, column}.
  gtea_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (PROD_DEPTH)
  ) u_prod_ram (
    .clk   (clk),
    .we    (prod_port.we),
    .waddr (prod_port.waddr),
    .wdata (prod_port.wdata),
    .raddr (prod_port.raddr),
    .rdata (prod_rdata)
  );

  // Inverse table, written alongside any load whose product is the identity.
  gtea_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (INV_DEPTH)
  ) u_inv_ram (
    .clk   (clk),
    .we    (inv_port.we),
    .waddr (inv_port.waddr),
    .wdata (inv_port.wdata),
    .raddr (inv_port.raddr),
    .rdata (inv_rdata)
  );

  // Output register: hold while stalled, drop valid once drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (take) begin
      element     <= res.element;
      order_count <= res.order_count;
      no_order    <= res.no_order;
    end
  end

endmodule
